/* hw/rtl/srot_pkg.sv */
// Shared types, constants and tables for the segment rotation pipeline.
`default_nettype none

package srot_pkg;

  localparam int COORD_BITS    = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int TAG_BITS      = 8;
  localparam int ANGLE_BITS    = 16;
  localparam int GUARD_BITS    = 8;
  localparam int IDX_BITS      = 4;

  // offset width, datapath width (guard bits plus CORDIC growth), angle width
  localparam int DW = COORD_BITS + 1;
  localparam int CW = COORD_BITS + GUARD_BITS + 4;
  localparam int ZW = 34;

  // gain multiply split into two partial products
  localparam int KB  = 20;
  localparam int LOW = CW / 2;
  localparam int HW  = CW - LOW;
  localparam int PLW = LOW + KB;
  localparam int PHW = HW + KB + 1;
  localparam int PW  = CW + KB + 1;
  localparam int QW  = PW - KB;
  localparam int SW  = QW + 1;

  localparam logic [KB-1:0]          GAIN_Q20   = KB'(636751);
  localparam logic signed [17:0]     RAD_TO_BAM = 18'sd83443;
  localparam logic signed [ZW-1:0]   Z_QUARTER  = ZW'(64'd1 << 30);
  localparam logic signed [ZW-1:0]   Z_HALF     = ZW'(64'd1 << 31);
  localparam logic signed [QW-1:0]   ROUND_HALF = QW'(64'd1 << (GUARD_BITS - 1));
  localparam logic signed [COORD_BITS-1:0] SAT_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] SAT_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam logic [IDX_BITS-1:0] REG_ANGLE     = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_ANCHOR_X  = IDX_BITS'(1);
  localparam logic [IDX_BITS-1:0] REG_ANCHOR_Y  = IDX_BITS'(2);
  localparam logic [IDX_BITS-1:0] REG_DIRECTION = IDX_BITS'(3);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CW-1:0]         cw_t;
  typedef logic signed [ZW-1:0]         z_t;

  typedef struct packed {
    logic                valid;
    logic [TAG_BITS-1:0] tag;
    logic                last;
  } ctl_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
  } vec_t;

  typedef struct packed {
    vec_t p0;
    vec_t p1;
  } seg_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } res_t;

  // atan(2^-i) in binary angle units, full turn = 2^32
  function automatic z_t atan_bam(input int i);
    z_t a;
    case (i)
      0:  a = ZW'(536870912);
      1:  a = ZW'(316933406);
      2:  a = ZW'(167458907);
      3:  a = ZW'(85004756);
      4:  a = ZW'(42667331);
      5:  a = ZW'(21354465);
      6:  a = ZW'(10679838);
      7:  a = ZW'(5340245);
      8:  a = ZW'(2670163);
      9:  a = ZW'(1335087);
      10: a = ZW'(667544);
      11: a = ZW'(333772);
      12: a = ZW'(166886);
      13: a = ZW'(83443);
      14: a = ZW'(41721);
      15: a = ZW'(20860);
      16: a = ZW'(10430);
      17: a = ZW'(5215);
      18: a = ZW'(2607);
      19: a = ZW'(1303);
      20: a = ZW'(651);
      21: a = ZW'(325);
      22: a = ZW'(162);
      23: a = ZW'(81);
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic vec_t cordic_step(input vec_t v, input logic pos, input int sh);
    cw_t  sx;
    cw_t  sy;
    vec_t r;
    sx = $signed(v.x) >>> sh;
    sy = $signed(v.y) >>> sh;
    if (pos) begin
      r.x = $signed(v.x) - sy;
      r.y = $signed(v.y) + sx;
    end else begin
      r.x = $signed(v.x) + sy;
      r.y = $signed(v.y) - sx;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/srot_prep.sv */
// Front end: anchor offsets, angle conversion and quadrant pre-rotation.
`default_nettype none

module srot_prep
  import srot_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctl_t                  in_ctl,
  input  wire coord_t                start_x,
  input  wire coord_t                start_y,
  input  wire coord_t                end_x,
  input  wire coord_t                end_y,
  input  wire logic [ANGLE_BITS-1:0] angle,
  input  wire logic                  direction,
  input  wire coord_t                anchor_x,
  input  wire coord_t                anchor_y,
  output ctl_t                       out_ctl,
  output z_t                         out_z,
  output seg_t                       out_seg
);

  logic signed [ANGLE_BITS:0] t;
  z_t                         z_mul;
  logic signed [DW-1:0]       d_next [4];

  ctl_t                 ctl_a;
  z_t                   z_a;
  logic signed [DW-1:0] d_a [4];

  logic                 flip;
  z_t                   z_red;
  cw_t                  v [4];

  ctl_t                 ctl_b;
  z_t                   z_b;
  seg_t                 seg_b;

  // stage A: angle to binary units, offsets from anchor
  always_comb begin
    t = direction ? -$signed({angle[ANGLE_BITS-1], angle})
                  :  $signed({angle[ANGLE_BITS-1], angle});
    z_mul = ZW'(t) * ZW'(RAD_TO_BAM);
    d_next[0] = DW'(start_x) - DW'(anchor_x);
    d_next[1] = DW'(start_y) - DW'(anchor_y);
    d_next[2] = DW'(end_x) - DW'(anchor_x);
    d_next[3] = DW'(end_y) - DW'(anchor_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else begin
      ctl_a <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    z_a <= z_mul;
    for (int k = 0; k < 4; k++) begin
      d_a[k] <= d_next[k];
    end
  end

  // stage B: fold angle into +-quarter turn, scale by guard bits
  always_comb begin
    flip  = 1'b0;
    z_red = z_a;
    if (z_a > Z_QUARTER) begin
      flip  = 1'b1;
      z_red = z_a - Z_HALF;
    end else if (z_a < -Z_QUARTER) begin
      flip  = 1'b1;
      z_red = z_a + Z_HALF;
    end
    for (int k = 0; k < 4; k++) begin
      v[k] = flip ? -CW'(d_a[k]) : CW'(d_a[k]);
      v[k] = v[k] <<< GUARD_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '0;
    end else begin
      ctl_b <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    z_b      <= z_red;
    seg_b.p0 <= '{x: v[0], y: v[1]};
    seg_b.p1 <= '{x: v[2], y: v[3]};
  end

  assign out_ctl = ctl_b;
  assign out_z   = z_b;
  assign out_seg = seg_b;

endmodule

`default_nettype wire

/* hw/rtl/srot_cordic.sv */
// Unrolled CORDIC rotation, one register stage per iteration, both endpoints.
`default_nettype none

module srot_cordic
  import srot_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire ctl_t in_ctl,
  input  wire z_t   in_z,
  input  wire seg_t in_seg,
  output ctl_t      out_ctl,
  output seg_t      out_seg
);

  ctl_t ctl_s [CORDIC_STAGES+1];
  z_t   z_s   [CORDIC_STAGES];
  seg_t seg_s [CORDIC_STAGES+1];

  assign ctl_s[0] = in_ctl;
  assign z_s[0]   = in_z;
  assign seg_s[0] = in_seg;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic pos;
    assign pos = ~z_s[i][ZW-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[i+1] <= '0;
      end else begin
        ctl_s[i+1] <= ctl_s[i];
      end
    end

    always_ff @(posedge clk) begin
      seg_s[i+1].p0 <= cordic_step(seg_s[i].p0, pos, i);
      seg_s[i+1].p1 <= cordic_step(seg_s[i].p1, pos, i);
    end

    if (i < CORDIC_STAGES - 1) begin : g_z
      always_ff @(posedge clk) begin
        z_s[i+1] <= pos ? z_s[i] - atan_bam(i) : z_s[i] + atan_bam(i);
      end
    end
  end

  assign out_ctl = ctl_s[CORDIC_STAGES];
  assign out_seg = seg_s[CORDIC_STAGES];

endmodule

`default_nettype wire

/* hw/rtl/srot_gain.sv */
// Gain compensation, guard-bit rounding, anchor add-back and saturation.
`default_nettype none

module srot_gain
  import srot_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire ctl_t   in_ctl,
  input  wire seg_t   in_seg,
  input  wire coord_t anchor_x,
  input  wire coord_t anchor_y,
  output ctl_t        out_ctl,
  output res_t        out_res
);

  cw_t    lane_v   [4];
  coord_t lane_anc [4];
  coord_t lane_res [4];

  ctl_t ctl_1;
  ctl_t ctl_2;
  ctl_t ctl_3;

  assign lane_v[0]   = in_seg.p0.x;
  assign lane_v[1]   = in_seg.p0.y;
  assign lane_v[2]   = in_seg.p1.x;
  assign lane_v[3]   = in_seg.p1.y;
  assign lane_anc[0] = anchor_x;
  assign lane_anc[1] = anchor_y;
  assign lane_anc[2] = anchor_x;
  assign lane_anc[3] = anchor_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_1 <= '0;
      ctl_2 <= '0;
      ctl_3 <= '0;
    end else begin
      ctl_1 <= in_ctl;
      ctl_2 <= ctl_1;
      ctl_3 <= ctl_2;
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [LOW-1:0]        lo;
    logic signed [HW-1:0]  hi;
    logic [PLW-1:0]        pp_lo;
    logic signed [PHW-1:0] pp_hi;
    logic signed [PW-1:0]  p_sum;
    logic signed [QW-1:0]  q;
    logic signed [QW-1:0]  rnd;
    logic signed [SW-1:0]  sum;
    coord_t                sat;

    assign lo = lane_v[l][LOW-1:0];
    assign hi = lane_v[l][CW-1:LOW];

    always_ff @(posedge clk) begin
      pp_lo <= PLW'(lo) * PLW'(GAIN_Q20);
      pp_hi <= PHW'(hi) * PHW'($signed({1'b0, GAIN_Q20}));
    end

    assign p_sum = (PW'(pp_hi) <<< LOW) + $signed(PW'(pp_lo));

    always_ff @(posedge clk) begin
      q <= QW'(p_sum >>> KB);
    end

    always_comb begin
      rnd = (q + ROUND_HALF) >>> GUARD_BITS;
      sum = SW'(rnd) + SW'(lane_anc[l]);
      if (sum > SW'(SAT_HI)) begin
        sat = SAT_HI;
      end else if (sum < SW'(SAT_LO)) begin
        sat = SAT_LO;
      end else begin
        sat = sum[COORD_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      lane_res[l] <= sat;
    end
  end

  assign out_ctl    = ctl_3;
  assign out_res.sx = lane_res[0];
  assign out_res.sy = lane_res[1];
  assign out_res.ex = lane_res[2];
  assign out_res.ey = lane_res[3];

endmodule

`default_nettype wire

/* hw/rtl/segment_rotate_about_anchor_top.sv */
// Top level: rotates segment endpoints about an anchor by a configured angle.
// Throughput: one segment per cycle; busy stays low, no stalls anywhere.
// Pipeline: 2 front-end stages, one stage per CORDIC iteration, 3 gain stages.
// Reset (rst, synchronous): clears all valid bits and config registers to 0.
// Results are strobed by done for one cycle; the receiver cannot stall.
`default_nettype none

module segment_rotate_about_anchor_top
  import srot_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [IDX_BITS-1:0]   cfg_index,
  input  wire logic [COORD_BITS-1:0] cfg_data,
  input  wire coord_t                start_x,
  input  wire coord_t                start_y,
  input  wire coord_t                end_x,
  input  wire coord_t                end_y,
  input  wire logic [TAG_BITS-1:0]   polygon_tag,
  input  wire logic                  last_segment,
  output logic                       done,
  output coord_t                     rot_start_x,
  output coord_t                     rot_start_y,
  output coord_t                     rot_end_x,
  output coord_t                     rot_end_y,
  output logic [TAG_BITS-1:0]        out_polygon_tag,
  output logic                       out_last
);

  logic [ANGLE_BITS-1:0] angle;
  coord_t                anchor_x;
  coord_t                anchor_y;
  logic                  direction;

  ctl_t in_ctl;
  ctl_t prep_ctl;
  z_t   prep_z;
  seg_t prep_seg;
  ctl_t cor_ctl;
  seg_t cor_seg;
  ctl_t res_ctl;
  res_t res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle     <= '0;
      anchor_x  <= '0;
      anchor_y  <= '0;
      direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ANGLE:     angle     <= cfg_data[ANGLE_BITS-1:0];
        REG_ANCHOR_X:  anchor_x  <= cfg_data;
        REG_ANCHOR_Y:  anchor_y  <= cfg_data;
        REG_DIRECTION: direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ctl = '{valid: start && !busy, tag: polygon_tag, last: last_segment};

  srot_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (in_ctl),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .angle     (angle),
    .direction (direction),
    .anchor_x  (anchor_x),
    .anchor_y  (anchor_y),
    .out_ctl   (prep_ctl),
    .out_z     (prep_z),
    .out_seg   (prep_seg)
  );

  srot_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (prep_ctl),
    .in_z    (prep_z),
    .in_seg  (prep_seg),
    .out_ctl (cor_ctl),
    .out_seg (cor_seg)
  );

  srot_gain u_gain (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (cor_ctl),
    .in_seg   (cor_seg),
    .anchor_x (anchor_x),
    .anchor_y (anchor_y),
    .out_ctl  (res_ctl),
    .out_res  (res)
  );

  assign done            = res_ctl.valid;
  assign rot_start_x     = res.sx;
  assign rot_start_y     = res.sy;
  assign rot_end_x       = res.ex;
  assign rot_end_y       = res.ey;
  assign out_polygon_tag = res_ctl.tag;
  assign out_last        = res_ctl.last;

endmodule

`default_nettype wire
